FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the bank switch mapper.
// No dependencies; define SYNTH to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SLB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define SLB_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define SLB_ASSERT(name, clk, rst, prop)
`define SLB_NEVER(name, clk, rst, cond)
`endif

`endif

FILE: hdl/slbsm_pkg.sv
// Types, codes and constants of the serial loaded bank switch mapper.
// No dependencies; imported by serial_loaded_bank_switch_mapper.
package slbsm_pkg;

   localparam logic [7:0] SIZE_1024K   = 8'd128;
   localparam logic [7:0] SIZE_512K    = 8'd64;
   localparam logic [7:0] SIZE_RESET   = 8'd32;
   localparam logic [4:0] CTRL_RESET   = 5'h0C;
   localparam int         BIT_4K       = 4;
   localparam int         BIT_16K      = 3;
   localparam int         BIT_LOW16    = 2;
   localparam int         DATA_CLEAR   = 7;
   localparam logic [2:0] SHIFT_LAST   = 3'd4;
   localparam logic [4:0] INNER_HI     = 5'd30;
   localparam logic [6:0] CHR_HI_RESET = 7'd4;

   typedef enum logic [1:0] {
      CSR_PRG_SIZE = 2'd0,
      CSR_CHR_ROM  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_CONTROL = 2'd0,
      SEL_CHR0    = 2'd1,
      SEL_CHR1    = 2'd2,
      SEL_PRG     = 2'd3
   } reg_sel_type;

   typedef struct packed {
      logic [3:0][6:0] prg_page;
      logic [6:0]      chr_page_low;
      logic [6:0]      chr_page_high;
      logic [1:0]      mirroring;
      logic            committed;
   } rsp_type;

   // low five bits of the last two banks for a given ROM size
   function automatic logic [4:0] hi_page(input logic [7:0] size, input logic k);
      logic is_small;
      is_small = (size != SIZE_1024K) && (size != SIZE_512K);
      if (is_small) begin
         return size[4:0] - 5'd2 + {4'd0, k};
      end
      return INNER_HI + {4'd0, k};
   endfunction

endpackage

FILE: hdl/serial_loaded_bank_switch_mapper.sv
// Serial loaded bank switch mapper: shifter, control registers, page mapping.
// Depends on slbsm_pkg and assert_macros.svh.
// Throughput: one request per cycle; a result register plus a skid register
// hold two results, so the input stalls only while both are full.
// Reset: synchronous; control register 0 to 0x0C, size 32, slots 0, 1, last two.
`include "assert_macros.svh"

module serial_loaded_bank_switch_mapper
   import slbsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_prg_page0,
   output logic [6:0]  rsp_prg_page1,
   output logic [6:0]  rsp_prg_page2,
   output logic [6:0]  rsp_prg_page3,
   output logic [6:0]  rsp_chr_page_low,
   output logic [6:0]  rsp_chr_page_high,
   output logic [1:0]  rsp_mirroring,
   output logic        rsp_committed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]      size_ff;
   logic            chr_rom_ff;
   logic [4:0]      bits_ff, bits_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [1:0]      region_ff;
   logic [3:0][4:0] ctrl_ff, ctrl_in;
   logic [1:0]      outer_ff, outer_in;
   logic            swap_ff, swap_in;
   logic [3:0][4:0] slot_ff, slot_in;
   logic [6:0]      chr_lo_ff, chr_lo_in;
   logic [6:0]      chr_hi_ff, chr_hi_in;
   logic [1:0]      mirror_ff, mirror_in;
   logic            committed;

   rsp_type         res;
   rsp_type         out_ff, skid_ff;
   logic            out_valid_ff, skid_valid_ff;
   logic            push, pop;

   logic [1:0]      region;
   reg_sel_type     sel;
   logic [4:0]      r0, v;
   logic [4:0]      b5;
   logic            big, mid, is_small, do_swap;

   assign region   = req_addr[14:13];
   assign sel      = reg_sel_type'(req_addr[14:13]);
   assign big      = (size_ff == SIZE_1024K);
   assign mid      = (size_ff == SIZE_512K);
   assign is_small = !big && !mid;

   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   always_comb begin
      bits_in   = bits_ff;
      cnt_in    = cnt_ff;
      ctrl_in   = ctrl_ff;
      outer_in  = outer_ff;
      swap_in   = swap_ff;
      slot_in   = slot_ff;
      chr_lo_in = chr_lo_ff;
      chr_hi_in = chr_hi_ff;
      mirror_in = mirror_ff;
      committed = 1'b0;
      do_swap   = 1'b0;
      r0        = ctrl_ff[0];
      v         = '0;
      b5        = '0;
      if ((region != region_ff) || req_data[DATA_CLEAR]) begin
         bits_in = '0;
         cnt_in  = '0;
      end
      if (!req_data[DATA_CLEAR]) begin
         bits_in = bits_in | ({4'd0, req_data[0]} << cnt_in);
         if (cnt_in == SHIFT_LAST) begin
            v            = bits_in;
            ctrl_in[sel] = bits_in;
            r0           = ctrl_in[0];
            b5           = {v[3:0], 1'b0};
            bits_in      = '0;
            cnt_in       = '0;
            committed    = 1'b1;
            unique case (sel)
               SEL_CONTROL: begin
                  mirror_in = r0[1:0];
               end
               SEL_CHR0: begin
                  priority if (big) begin
                     if (r0[BIT_4K]) begin
                        do_swap = 1'b1;
                     end else begin
                        outer_in = {2{v[BIT_4K]}};
                     end
                  end else if (mid && !chr_rom_ff) begin
                     outer_in = {1'b0, v[BIT_4K]};
                  end else if (chr_rom_ff) begin
                     chr_lo_in = {v, 2'b00};
                     if (!r0[BIT_4K]) begin
                        chr_hi_in = {v, 2'b00} + 7'd4;
                     end
                  end else begin
                     if (r0[BIT_4K]) begin
                        chr_lo_in = {v, 2'b00};
                     end
                  end
               end
               SEL_CHR1: begin
                  do_swap = big && r0[BIT_16K];
                  if (r0[BIT_4K]) begin
                     chr_hi_in = {v, 2'b00};
                  end
               end
               SEL_PRG: begin
                  priority if (r0[BIT_16K]) begin
                     if (r0[BIT_LOW16]) begin
                        slot_in[0] = b5;
                        slot_in[1] = b5 + 5'd1;
                        slot_in[2] = hi_page(size_ff, 1'b0);
                        slot_in[3] = hi_page(size_ff, 1'b1);
                     end else if (is_small) begin
                        slot_in[0] = 5'd0;
                        slot_in[1] = 5'd1;
                        slot_in[2] = b5;
                        slot_in[3] = b5 + 5'd1;
                     end
                  end else if (is_small) begin
                     slot_in[0] = b5;
                     slot_in[1] = b5 + 5'd1;
                     slot_in[2] = b5 + 5'd2;
                     slot_in[3] = b5 + 5'd3;
                  end else begin
                     slot_in[0] = b5;
                     slot_in[1] = b5 + 5'd1;
                  end
               end
            endcase
            if (do_swap) begin
               if (swap_ff) begin
                  outer_in = {r0[BIT_16K] & ctrl_in[2][BIT_4K], ctrl_in[1][BIT_4K]};
                  swap_in  = 1'b0;
               end else begin
                  swap_in = 1'b1;
               end
            end
         end else begin
            cnt_in = cnt_in + 3'd1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         res.prg_page[i] = {outer_in, slot_in[i]};
      end
      res.chr_page_low  = chr_lo_in;
      res.chr_page_high = chr_hi_in;
      res.mirroring     = mirror_in;
      res.committed     = committed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SIZE_RESET;
         chr_rom_ff <= 1'b1;
         bits_ff    <= '0;
         cnt_ff     <= '0;
         region_ff  <= '0;
         ctrl_ff    <= {5'd0, 5'd0, 5'd0, CTRL_RESET};
         outer_ff   <= '0;
         swap_ff    <= 1'b0;
         slot_ff    <= {hi_page(SIZE_RESET, 1'b1), hi_page(SIZE_RESET, 1'b0), 5'd1, 5'd0};
         chr_lo_ff  <= '0;
         chr_hi_ff  <= CHR_HI_RESET;
         mirror_ff  <= '0;
      end else begin
         if (push) begin
            bits_ff   <= bits_in;
            cnt_ff    <= cnt_in;
            region_ff <= region;
            ctrl_ff   <= ctrl_in;
            outer_ff  <= outer_in;
            swap_ff   <= swap_in;
            chr_lo_ff <= chr_lo_in;
            chr_hi_ff <= chr_hi_in;
            mirror_ff <= mirror_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PRG_SIZE: begin
                  size_ff <= csr_data;
               end
               CSR_CHR_ROM: begin
                  chr_rom_ff <= csr_data[0];
               end
               default: begin
               end
            endcase
         end
         if (csr_valid && csr_ready && (csr_index == CSR_PRG_SIZE)) begin
            slot_ff <= {hi_page(csr_data, 1'b1), hi_page(csr_data, 1'b0), 5'd1, 5'd0};
         end else if (push) begin
            slot_ff <= slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || pop) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= push;
            end else begin
               out_valid_ff <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (push) begin
               skid_ff <= res;
            end
         end else if (push) begin
            out_ff <= res;
         end
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_prg_page0     = out_ff.prg_page[0];
   assign rsp_prg_page1     = out_ff.prg_page[1];
   assign rsp_prg_page2     = out_ff.prg_page[2];
   assign rsp_prg_page3     = out_ff.prg_page[3];
   assign rsp_chr_page_low  = out_ff.chr_page_low;
   assign rsp_chr_page_high = out_ff.chr_page_high;
   assign rsp_mirroring     = out_ff.mirroring;
   assign rsp_committed     = out_ff.committed;

   `SLB_NEVER(a_skid_without_out, clock, reset, skid_valid_ff && !out_valid_ff)
   `SLB_NEVER(a_count_range, clock, reset, cnt_ff > SHIFT_LAST)
   `SLB_ASSERT(a_commit_clears, clock, reset, (push && committed) |=> (cnt_ff == 3'd0 && bits_ff == 5'd0))
   `SLB_ASSERT(a_size_reload, clock, reset, (csr_valid && csr_index == CSR_PRG_SIZE) |=> (slot_ff[0] == 5'd0 && slot_ff[1] == 5'd1))

endmodule

FILE: test/serial_loaded_bank_switch_mapper_test.sv
`timescale 1ns / 100ps
// Self-checking bench for serial_loaded_bank_switch_mapper: serial register loads,
// ROM size and character memory settings, every mapping checked per CPU write.
// Depends on slbsm_pkg and the mapper RTL.
module serial_loaded_bank_switch_mapper_test;
   import slbsm_pkg::*;

   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam int         PHASE_WRITES = 216;
   localparam int         PHASES       = 8;
   localparam int         DRAIN_CYCLES = 4;
   localparam int         HOLD_AFTER   = 300;
   localparam int         HOLD_CYCLES  = 150;
   localparam int         MAX_REPORTS  = 100;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  data;
   } cpu_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_addr = '0;
   logic [7:0]  req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_prg_page0;
   logic [6:0]  rsp_prg_page1;
   logic [6:0]  rsp_prg_page2;
   logic [6:0]  rsp_prg_page3;
   logic [6:0]  rsp_chr_page_low;
   logic [6:0]  rsp_chr_page_high;
   logic [1:0]  rsp_mirroring;
   logic        rsp_committed;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   logic        rsp_hold = 1'b0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          writes_accepted = 0;
   int          writes_queued = 0;
   int          mismatches = 0;

   cpu_write_type pending_writes[$];
   rsp_type       expected_maps[$];

   // mapping state mirrored by the bench
   logic [7:0] rom_banks;
   logic       chr_rom;
   logic [4:0] shifter;
   logic [2:0] shift_len;
   logic [1:0] prev_region;
   logic [4:0] ctrl_reg [4];
   logic [1:0] outer_base;
   logic       swap_armed;
   logic [6:0] prg_slot [4];
   logic [6:0] chr_low;
   logic [6:0] chr_high;
   logic [1:0] mirror;

   serial_loaded_bank_switch_mapper u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_addr          (req_addr),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_prg_page0     (rsp_prg_page0),
      .rsp_prg_page1     (rsp_prg_page1),
      .rsp_prg_page2     (rsp_prg_page2),
      .rsp_prg_page3     (rsp_prg_page3),
      .rsp_chr_page_low  (rsp_chr_page_low),
      .rsp_chr_page_high (rsp_chr_page_high),
      .rsp_mirroring     (rsp_mirroring),
      .rsp_committed     (rsp_committed),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   function automatic logic small_rom();
      return rom_banks != SIZE_1024K && rom_banks != SIZE_512K;
   endfunction

   function automatic logic [6:0] last_bank(input logic k);
      logic [7:0] bank;
      if (small_rom()) begin
         bank = rom_banks - 8'd2 + {7'd0, k};
         return bank[6:0];
      end
      return 7'(INNER_HI) + {6'd0, k};
   endfunction

   task automatic reload_slots();
      prg_slot[0] = 7'd0;
      prg_slot[1] = 7'd1;
      prg_slot[2] = last_bank(1'b0);
      prg_slot[3] = last_bank(1'b1);
   endtask

   task automatic reset_mapping_model();
      rom_banks   = SIZE_RESET;
      chr_rom     = 1'b1;
      shifter     = '0;
      shift_len   = '0;
      prev_region = '0;
      ctrl_reg[0] = CTRL_RESET;
      ctrl_reg[1] = '0;
      ctrl_reg[2] = '0;
      ctrl_reg[3] = '0;
      outer_base  = '0;
      swap_armed  = 1'b0;
      chr_low     = '0;
      chr_high    = CHR_HI_RESET;
      mirror      = '0;
      reload_slots();
   endtask

   // 1024K ROMs move the outer base on every second CHR0 load in 4K mode or CHR1 load with BIT_16K set
   task automatic step_outer_swap();
      if (swap_armed) begin
         outer_base = {ctrl_reg[0][BIT_16K] & ctrl_reg[2][BIT_4K], ctrl_reg[1][BIT_4K]};
         swap_armed = 1'b0;
      end else begin
         swap_armed = 1'b1;
      end
   endtask

   task automatic commit_register(input reg_sel_type sel);
      logic [4:0] r0;
      logic [4:0] v;
      logic [6:0] b;
      logic       big;
      r0  = ctrl_reg[0];
      v   = ctrl_reg[sel];
      b   = {1'b0, v, 1'b0};
      big = rom_banks == SIZE_1024K;
      case (sel)
         SEL_CONTROL: begin
            mirror = r0[1:0];
         end
         SEL_CHR0: begin
            if (big) begin
               if (r0[BIT_4K]) begin
                  step_outer_swap();
               end else begin
                  outer_base = v[BIT_4K] ? 2'd3 : 2'd0;
               end
            end else if (rom_banks == SIZE_512K && !chr_rom) begin
               outer_base = {1'b0, v[BIT_4K]};
            end else if (chr_rom) begin
               chr_low = {v, 2'b00};
               if (!r0[BIT_4K]) begin
                  chr_high = {v, 2'b00} + 7'd4;
               end
            end else if (r0[BIT_4K]) begin
               chr_low = {v, 2'b00};
            end
         end
         SEL_CHR1: begin
            if (big && r0[BIT_16K]) begin
               step_outer_swap();
            end
            if (r0[BIT_4K]) begin
               chr_high = {v, 2'b00};
            end
         end
         SEL_PRG: begin
            if (r0[BIT_16K]) begin
               if (r0[BIT_LOW16]) begin
                  prg_slot[0] = b;
                  prg_slot[1] = b + 7'd1;
                  prg_slot[2] = last_bank(1'b0);
                  prg_slot[3] = last_bank(1'b1);
               end else if (small_rom()) begin
                  prg_slot[0] = 7'd0;
                  prg_slot[1] = 7'd1;
                  prg_slot[2] = b;
                  prg_slot[3] = b + 7'd1;
               end
            end else if (small_rom()) begin
               prg_slot[0] = b;
               prg_slot[1] = b + 7'd1;
               prg_slot[2] = b + 7'd2;
               prg_slot[3] = b + 7'd3;
            end else begin
               prg_slot[0] = b;
               prg_slot[1] = b + 7'd1;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic apply_cpu_write(input logic [15:0] addr, input logic [7:0] data);
      rsp_type    mapping;
      logic [1:0] region;
      logic       done;
      region = addr[14:13];
      done   = 1'b0;
      if (region != prev_region) begin
         shifter   = '0;
         shift_len = '0;
      end
      prev_region = region;
      if (data[DATA_CLEAR]) begin
         shifter   = '0;
         shift_len = '0;
      end else begin
         if (data[0]) begin
            shifter[shift_len] = 1'b1;
         end
         if (shift_len == SHIFT_LAST) begin
            ctrl_reg[region] = shifter;
            shifter   = '0;
            shift_len = '0;
            done      = 1'b1;
            commit_register(reg_sel_type'(region));
         end else begin
            shift_len = shift_len + 3'd1;
         end
      end
      for (int i = 0; i < 4; i++) begin
         mapping.prg_page[i] = {outer_base, prg_slot[i][4:0]};
      end
      mapping.chr_page_low  = chr_low;
      mapping.chr_page_high = chr_high;
      mapping.mirroring     = mirror;
      mapping.committed     = done;
      expected_maps.push_back(mapping);
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t: mapping mismatch, %s", $time, what);
      end
      mismatches++;
   endtask

   task automatic queue_write(input logic [15:0] addr, input logic [7:0] data);
      pending_writes.push_back('{addr: addr, data: data});
      writes_queued++;
   endtask

   function automatic logic [15:0] region_addr(input logic [1:0] region);
      logic [15:0] addr;
      addr = 16'($urandom);
      addr[14:13] = region;
      return addr;
   endfunction

   task automatic queue_serial_load(input logic [1:0] region, input logic [4:0] value);
      for (int i = 0; i < 5; i++) begin
         queue_write(region_addr(region), {1'b0, 6'($urandom), value[i]});
      end
   endtask

   task automatic queue_random_writes(input int count);
      int         target;
      int         kind;
      logic [1:0] region;
      target = writes_queued + count;
      while (writes_queued < target) begin
         kind   = $urandom_range(99);
         region = 2'($urandom_range(3));
         if (kind < 70) begin
            if ($urandom_range(1) == 1) begin
               queue_write(region_addr(region), 8'h80 | 8'($urandom));
            end
            queue_serial_load(region, 5'($urandom));
         end else if (kind < 85) begin
            repeat ($urandom_range(4, 1)) begin
               queue_write(region_addr(region), 8'($urandom) & 8'h7F);
            end
         end else begin
            queue_write(16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_PRG_SIZE) begin
         rom_banks = value;
         reload_slots();
      end else if (index == CSR_CHR_ROM) begin
         chr_rom = value[0];
      end
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_writes.size() != 0 || req_valid || expected_maps.size() != 0);
   endtask

   task automatic setup_phase(input int phase);
      logic [7:0] size;
      logic       rom;
      case (phase)
         0: begin size = SIZE_1024K; rom = 1'b1; end
         1: begin size = SIZE_1024K; rom = 1'b0; end
         2: begin size = SIZE_512K;  rom = 1'b0; end
         3: begin size = SIZE_512K;  rom = 1'b1; end
         4: begin size = 8'd2;       rom = 1'b0; end
         5: begin size = 8'd0;       rom = 1'b1; end
         6: begin size = 8'd255;     rom = 1'b0; end
         default: begin size = 8'd3; rom = 1'b1; end
      endcase
      if (phase == 0) begin
         write_csr(CSR_UNUSED, 8'hA5);
      end
      write_csr(CSR_CHR_ROM, {7'($urandom), rom});
      write_csr(CSR_PRG_SIZE, size);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      reset_mapping_model();
      tx_idle_pct = 19;
      rx_idle_pct = 65;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_write(16'hFFFF, 8'hFF);
      queue_write(16'h0000, 8'h00);
      queue_write(16'hA000, 8'h01);
      queue_write(16'h8000, 8'h80);
      queue_serial_load(2'(SEL_CONTROL), 5'h1C);
      queue_serial_load(2'(SEL_CHR0), 5'h15);
      queue_serial_load(2'(SEL_CHR1), 5'h0A);
      queue_serial_load(2'(SEL_PRG), 5'h1F);
      wait_for_drain();
      for (int phase = 0; phase < PHASES; phase++) begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         setup_phase(phase);
         @(negedge clock);
         if (phase < 3) begin
            tx_idle_pct = 19;
            rx_idle_pct = 65;
         end else if (phase < 6) begin
            tx_idle_pct = 65;
            rx_idle_pct = 19;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         queue_random_writes(PHASE_WRITES);
         wait_for_drain();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("serial_loaded_bank_switch_mapper test passed");
      end else begin
         $display("serial_loaded_bank_switch_mapper test failed");
      end
      $finish;
   end

   initial begin
      wait (writes_accepted >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("serial_loaded_bank_switch_mapper test failed");
      $finish;
   end

   always @(posedge clock) begin
      cpu_write_type next_write;
      logic          held;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         held = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            apply_cpu_write(req_addr, req_data);
            writes_accepted++;
         end
         if (!held) begin
            if (pending_writes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               next_write = pending_writes.pop_front();
               req_valid <= 1'b1;
               req_addr  <= next_write.addr;
               req_data  <= next_write.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.prg_page[0]   = rsp_prg_page0;
            got.prg_page[1]   = rsp_prg_page1;
            got.prg_page[2]   = rsp_prg_page2;
            got.prg_page[3]   = rsp_prg_page3;
            got.chr_page_low  = rsp_chr_page_low;
            got.chr_page_high = rsp_chr_page_high;
            got.mirroring     = rsp_mirroring;
            got.committed     = rsp_committed;
            if (expected_maps.size() == 0) begin
               report_mismatch("mapping transfer with no write outstanding");
            end else begin
               want = expected_maps.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (got.prg_page[i] !== want.prg_page[i]) begin
                     report_mismatch($sformatf("prg_page%0d got %0d expected %0d",
                        i, got.prg_page[i], want.prg_page[i]));
                  end
               end
               if (got.chr_page_low !== want.chr_page_low) begin
                  report_mismatch($sformatf("chr_page_low got %0d expected %0d",
                     got.chr_page_low, want.chr_page_low));
               end
               if (got.chr_page_high !== want.chr_page_high) begin
                  report_mismatch($sformatf("chr_page_high got %0d expected %0d",
                     got.chr_page_high, want.chr_page_high));
               end
               if (got.mirroring !== want.mirroring) begin
                  report_mismatch($sformatf("mirroring got %0d expected %0d",
                     got.mirroring, want.mirroring));
               end
               if (got.committed !== want.committed) begin
                  report_mismatch($sformatf("committed got %0d expected %0d",
                     got.committed, want.committed));
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

endmodule
